/* hdl/mgm_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mgm_pkg
// Shared types, constants and round helpers for the Magma-style block cipher.
// -----------------------------------------------------------------------------
package mgm_pkg;

   localparam int ROUNDS     = 32;
   localparam int ROUND_W    = $clog2(ROUNDS);
   localparam int ROT_BITS   = 11;
   localparam int KEY_W      = 56;
   localparam int KEY_BYTES  = KEY_W / 8;
   localparam int WORD_W     = 32;
   localparam int BLOCK_W    = 2 * WORD_W;
   localparam int NUM_WORDS  = 8;
   localparam int WIDX_W     = $clog2(NUM_WORDS);
   // Rounds that walk the key words forward before the reversed pass.
   localparam int FWD_ROUNDS = ROUNDS - NUM_WORDS;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [ROUND_W-1:0] round_idx_type;
   typedef logic [WIDX_W-1:0]  word_idx_type;
   typedef word_type key_words_type [NUM_WORDS];

   typedef struct packed {
      logic     op;
      word_type hi;
      word_type lo;
   } stage_type;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [3:0] SBOX [NUM_WORDS][16] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd15, 4'd3,  4'd7,  4'd1,  4'd0},
      '{4'd15, 4'd12, 4'd8,  4'd2,  4'd10, 4'd0,  4'd4,  4'd13,
        4'd14, 4'd9,  4'd1,  4'd7,  4'd6,  4'd3,  4'd11, 4'd5},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd0,  4'd15, 4'd13, 4'd11},
      '{4'd12, 4'd7,  4'd2,  4'd1,  4'd6,  4'd0,  4'd8,  4'd13,
        4'd3,  4'd15, 4'd9,  4'd10, 4'd4,  4'd5,  4'd14, 4'd11},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd1,  4'd8,
        4'd0,  4'd14, 4'd10, 4'd4,  4'd7,  4'd3,  4'd11, 4'd12},
      '{4'd8,  4'd14, 4'd7,  4'd11, 4'd0,  4'd10, 4'd9,  4'd1,
        4'd13, 4'd3,  4'd15, 4'd6,  4'd2,  4'd5,  4'd12, 4'd4},
      '{4'd9,  4'd6,  4'd3,  4'd15, 4'd1,  4'd13, 4'd14, 4'd0,
        4'd11, 4'd2,  4'd8,  4'd5,  4'd12, 4'd10, 4'd4,  4'd7}
   };

   // Key word used by encryption round idx.
   function automatic word_idx_type sched_word(input round_idx_type idx);
      word_idx_type low;
      low = idx[WIDX_W-1:0];
      if (32'(idx) < FWD_ROUNDS) begin
         return low;
      end
      return word_idx_type'(NUM_WORDS - 1) - low;
   endfunction

   // Add key, substitute nibble i through box i, rotate left.
   function automatic word_type round_f(input word_type x, input word_type k);
      word_type s;
      word_type t;
      s = x + k;
      for (int i = 0; i < NUM_WORDS; i++) begin
         t[4*i +: 4] = SBOX[i][s[4*i +: 4]];
      end
      return (t << ROT_BITS) | (t >> (WORD_W - ROT_BITS));
   endfunction

endpackage

/* hdl/magma_style_block_cipher.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// magma_style_block_cipher
// 64-bit Feistel block cipher with a 56-bit key, one round per pipeline stage.
// -----------------------------------------------------------------------------
// Usage:
// Write the key through csr_write_enable / csr_write_data while no item is in
// flight. Each request item carries req_op (0 encrypt, 1 decrypt) and a 64-bit
// block; each response item carries the transformed block, in request order.
// An item is taken when valid is high and stall is low on that channel.
// An accepted item passes through one register stage per round, the last
// stage doubling as the output register, and then raises rsp_valid.
// Throughput is one item per cycle while the response side does not stall,
// set by the 32-stage round pipeline.
// When the response side stalls while a result is waiting, the whole
// pipeline freezes and req_stall is raised; nothing is dropped or repeated,
// and empty stages do not advance either during that time.
// Reset clears the key to zero and empties the pipeline.
// -----------------------------------------------------------------------------
module magma_style_block_cipher (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  mgm_pkg::key_type   csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  mgm_pkg::block_type req_block_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mgm_pkg::block_type rsp_block_out
);
   import mgm_pkg::*;

   key_words_type key_words;
   logic          advance;
   logic          st_valid [ROUNDS+1];
   stage_type     st_data  [ROUNDS+1];

   mgm_key_sched u_key_sched (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .key_words        (key_words)
   );

   // The pipeline moves as one unless a finished item is held at the output.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign st_valid[0]   = req_valid;
   assign st_data[0].op = req_op;
   assign st_data[0].hi = req_block_in[BLOCK_W-1:WORD_W];
   assign st_data[0].lo = req_block_in[WORD_W-1:0];

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      mgm_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .round_idx (round_idx_type'(r)),
         .key_words (key_words),
         .valid_i   (st_valid[r]),
         .data_i    (st_data[r]),
         .valid_o   (st_valid[r+1]),
         .data_o    (st_data[r+1])
      );
   end

   assign rsp_valid     = st_valid[ROUNDS];
   assign rsp_block_out = {st_data[ROUNDS].hi, st_data[ROUNDS].lo};

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> st_valid[1])
      else $error("accepted item did not enter the first round stage");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      advance && st_valid[ROUNDS-1] |=> rsp_valid)
      else $error("item lost between the last two round stages");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> st_valid[1] == $past(st_valid[1]) &&
                   st_valid[ROUNDS/2] == $past(st_valid[ROUNDS/2]))
      else $error("pipeline moved while the output was held");

   a_held_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(st_data[ROUNDS]))
      else $error("held result changed under stall");

endmodule

/* hdl/mgm_key_sched.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mgm_key_sched
// Holds the 56-bit key and spreads its bytes into the eight round key words.
// -----------------------------------------------------------------------------
module mgm_key_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  mgm_pkg::key_type      csr_write_data,
   output mgm_pkg::key_words_type key_words
);
   import mgm_pkg::*;

   key_type key_ff;
   key_type key_in;

   assign key_in = csr_write_enable ? csr_write_data : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // The seven key bytes repeat cyclically to fill 32 bytes; word w is
   // bytes 4w..4w+3 with the first byte most significant.
   for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
      for (genvar j = 0; j < 4; j++) begin : g_byte
         localparam int POS = (4 * w + j) % KEY_BYTES;
         assign key_words[w][8*(3-j) +: 8] = key_ff[8*(KEY_BYTES-1-POS) +: 8];
      end
   end

endmodule

/* hdl/mgm_round.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mgm_round
// One registered Feistel round; the final round leaves the halves unswapped.
// -----------------------------------------------------------------------------
module mgm_round (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  mgm_pkg::round_idx_type round_idx,
   input  mgm_pkg::key_words_type key_words,
   input  logic                   valid_i,
   input  mgm_pkg::stage_type     data_i,
   output logic                   valid_o,
   output mgm_pkg::stage_type     data_o
);
   import mgm_pkg::*;

   logic          valid_ff;
   stage_type     data_ff;
   stage_type     data_in;
   round_idx_type sched_idx;
   word_type      rkey;
   word_type      mixed;

   // Decryption walks the encryption schedule backwards.
   assign sched_idx = (data_i.op == OP_DECRYPT) ?
                      round_idx_type'(ROUNDS - 1) - round_idx : round_idx;
   assign rkey      = key_words[sched_word(sched_idx)];
   assign mixed     = data_i.lo ^ round_f(data_i.hi, rkey);

   always_comb begin
      data_in.op = data_i.op;
      if (32'(round_idx) == ROUNDS - 1) begin
         data_in.hi = data_i.hi;
         data_in.lo = mixed;
      end else begin
         data_in.hi = mixed;
         data_in.lo = data_i.hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule
